>>> sv/wdfc_pkg.sv
// Package: widths, constants and shared types of the descrambler / FCS checker.
package wdfc_pkg;

   localparam int unsigned FRAME_BYTES_W       = 12;
   localparam int unsigned BIT_COUNT_W         = 16;
   localparam int unsigned SCRAM_W             = 7;
   localparam int unsigned CRC_W               = 32;
   localparam int unsigned MAX_FRAME_BYTES_DEF = 4095;

   // Bit positions inside a frame.
   localparam logic [BIT_COUNT_W-1:0] SEED_BITS    = BIT_COUNT_W'(7);
   localparam logic [2:0]             BYTE_LAST_POS = 3'd7;

   localparam logic [CRC_W-1:0] CRC_POLY_REFL = 32'hEDB8_8320;
   localparam logic [CRC_W-1:0] CRC_PRESET    = 32'hFFFF_FFFF;
   // Register value that matches a residue of 0x2144DF1C after final inversion.
   localparam logic [CRC_W-1:0] CRC_GOOD      = ~32'h2144_DF1C;

   typedef struct packed {
      logic                     active;
      logic [SCRAM_W-1:0]       scram;
      logic [BIT_COUNT_W-1:0]   bit_count;
      logic [7:0]               byte_shift;
      logic [CRC_W-1:0]         crc;
      logic [FRAME_BYTES_W-1:0] length_held;
   } frame_state_type;

   typedef struct packed {
      logic                     coded_bit;
      logic                     frame_start;
      logic [FRAME_BYTES_W-1:0] frame_bytes;
   } req_item_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       fcs_ok;
   } rsp_item_type;

   function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
                                                input logic d);
      logic [CRC_W-1:0] sh;
      sh = crc >> 1;
      return (crc[0] ^ d) ? (sh ^ CRC_POLY_REFL) : sh;
   endfunction

endpackage

>>> sv/wdfc_if.sv
// Interfaces: valid/ready channels for decoded bits and for PSDU bytes.
interface wdfc_req_if import wdfc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     coded_bit;
   logic                     frame_start;
   logic [FRAME_BYTES_W-1:0] frame_bytes;

   modport source (output valid, output coded_bit, output frame_start,
                   output frame_bytes, input ready);
   modport sink   (input valid, input coded_bit, input frame_start,
                   input frame_bytes, output ready);
endinterface

interface wdfc_rsp_if ();
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   logic       fcs_ok;

   modport source (output valid, output data_byte, output last_byte,
                   output fcs_ok, input ready);
   modport sink   (input valid, input data_byte, input last_byte,
                   input fcs_ok, output ready);
endinterface

>>> sv/wdfc_bit_step.sv
// Per-bit step: frame start, scrambler seed/feedback, byte packing, CRC, last-byte check.
module wdfc_bit_step import wdfc_pkg::*; #(
   parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
   input  frame_state_type state_cur,
   input  req_item_type    item,
   output frame_state_type state_nxt,
   output logic            emit,
   output rsp_item_type    result
);

   localparam logic [BIT_COUNT_W:0] MAX_LEN = (BIT_COUNT_W+1)'(MAX_FRAME_BYTES);

   always_comb begin
      frame_state_type st;
      logic [BIT_COUNT_W-1:0] i;
      logic fb;
      logic d;
      logic last;

      st     = state_cur;
      emit   = 1'b0;
      result = '0;
      i      = '0;
      fb     = 1'b0;
      d      = 1'b0;
      last   = 1'b0;

      if (item.frame_start) begin
         st.scram       = '0;
         st.bit_count   = '0;
         st.byte_shift  = '0;
         st.crc         = CRC_PRESET;
         st.length_held = item.frame_bytes;
         st.active      = ((BIT_COUNT_W+1)'(item.frame_bytes) <= MAX_LEN);
      end

      if (st.active) begin
         i            = st.bit_count;
         st.bit_count = i + BIT_COUNT_W'(1);
         if (i < SEED_BITS) begin
            // seed: first bit lands in the MSB
            st.scram = st.scram | (SCRAM_W'(item.coded_bit) << (3'd6 - i[2:0]));
         end else begin
            fb       = st.scram[6] ^ st.scram[3];
            d        = fb ^ item.coded_bit;
            st.scram = {st.scram[5:0], fb};
            if (i == SEED_BITS) begin
               // end of service byte
               if (st.length_held == '0) begin
                  st.active = 1'b0;
               end
            end else begin
               st.byte_shift = st.byte_shift | (8'(d) << i[2:0]);
               st.crc        = crc_step(st.crc, d);
               if (i[2:0] == BYTE_LAST_POS) begin
                  // bytes done so far = i >> 3 (service byte excluded by the -1 +1)
                  last             = (i[BIT_COUNT_W-1:3] >=
                                      (BIT_COUNT_W-3)'(st.length_held));
                  emit             = 1'b1;
                  result.data_byte = st.byte_shift;
                  result.last_byte = last;
                  result.fcs_ok    = last && (st.crc == CRC_GOOD);
                  st.byte_shift    = '0;
                  if (last) begin
                     st.active = 1'b0;
                  end
               end
            end
         end
      end

      state_nxt = st;
   end

endmodule

>>> sv/wlan_descramble_fcs_check.sv
// Top level: 802.11 PSDU descrambler with CRC-32 FCS check.
//
//   channel | dir | beat content                            | handshake
//   req_bus | in  | coded_bit, frame_start, frame_bytes     | valid/ready
//   rsp_bus | out | data_byte, last_byte, fcs_ok            | valid/ready
//
// One bit per cycle sustained while rsp_bus is not stalled. A bit is registered
// in the input register on acceptance and processed as it leaves (LFSR step,
// byte pack, one CRC step); a finished byte is registered for rsp_bus.
// Synchronous reset clears frame state to idle with the CRC preset.
// A stalled rsp_bus holds the byte; one further bit waits in the input register,
// then req_bus.ready drops until the byte is taken.
module wlan_descramble_fcs_check import wdfc_pkg::*; #(
   parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   wdfc_req_if.sink   req_bus,
   wdfc_rsp_if.source rsp_bus
);

   logic            in_valid_ff, in_valid_in;
   req_item_type    in_item_ff,  in_item_in;
   frame_state_type state_ff,    state_in;
   logic            out_valid_ff, out_valid_in;
   rsp_item_type    out_item_ff,  out_item_in;

   frame_state_type state_nxt;
   logic            emit;
   rsp_item_type    result;
   logic            advance;
   logic            req_fire;

   wdfc_bit_step #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_step (
      .state_cur(state_ff),
      .item     (in_item_ff),
      .state_nxt(state_nxt),
      .emit     (emit),
      .result   (result)
   );

   // registered bit may move on when the output register is free or draining
   assign advance         = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready   = !in_valid_ff || advance;
   assign req_fire        = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.data_byte = out_item_ff.data_byte;
   assign rsp_bus.last_byte = out_item_ff.last_byte;
   assign rsp_bus.fcs_ok    = out_item_ff.fcs_ok;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_item_in   = in_item_ff;
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;

      if (out_valid_ff && rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         in_valid_in = 1'b0;
         state_in    = state_nxt;
         if (emit) begin
            out_valid_in = 1'b1;
            out_item_in  = result;
         end
      end
      if (req_fire) begin
         in_valid_in            = 1'b1;
         in_item_in.coded_bit   = req_bus.coded_bit;
         in_item_in.frame_start = req_bus.frame_start;
         in_item_in.frame_bytes = req_bus.frame_bytes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff           <= 1'b0;
         out_valid_ff          <= 1'b0;
         state_ff.active       <= 1'b0;
         state_ff.scram        <= '0;
         state_ff.bit_count    <= '0;
         state_ff.byte_shift   <= '0;
         state_ff.crc          <= CRC_PRESET;
         state_ff.length_held  <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      (advance && emit && result.last_byte) |=> !state_ff.active)
      else $error("frame still active after last byte");

   assert property (@(posedge clock) disable iff (reset)
      (advance && emit) |-> (state_ff.bit_count[2:0] == BYTE_LAST_POS || in_item_ff.frame_start))
      else $error("byte emitted off a byte boundary");

   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (!rsp_bus.fcs_ok || rsp_bus.last_byte))
      else $error("fcs_ok set on a byte that is not last");

   assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (in_valid_ff && out_valid_ff && !rsp_bus.ready))
      else $error("input stalled while pipeline can move");

endmodule
